@@ hw/rtl/gfi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfi_pkg
// Shared constants and field arithmetic for the GF(2^8) inverse block.
// ----------------------------------------------------------------------------
package gfi_pkg;
  localparam int unsigned DataW = 8;
  localparam int unsigned PolyW = 9;
  localparam logic [PolyW-1:0] FieldPoly = 9'h11B;
  localparam int unsigned NumCells = 6;
  localparam int unsigned ProdW = 2 * DataW - 1;

  function automatic logic [DataW-1:0] gf_reduce(input logic [ProdW-1:0] prod);
    logic [ProdW-1:0] acc;
    acc = prod;
    for (int i = ProdW - 1; i >= DataW; i--) begin
      if (acc[i]) acc = acc ^ (ProdW'(FieldPoly) << (i - DataW));
    end
    return acc[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] gf_mul(input logic [DataW-1:0] a,
                                              input logic [DataW-1:0] b);
    logic [ProdW-1:0] prod;
    prod = '0;
    for (int i = 0; i < DataW; i++) begin
      if (b[i]) prod = prod ^ (ProdW'(a) << i);
    end
    return gf_reduce(prod);
  endfunction

  // Squaring is linear in GF(2^8): spread the bits, then reduce.
  function automatic logic [DataW-1:0] gf_sq(input logic [DataW-1:0] a);
    logic [ProdW-1:0] spread;
    spread = '0;
    for (int i = 0; i < DataW; i++) spread[2*i] = a[i];
    return gf_reduce(spread);
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/gfi_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfi_cell
// One square-and-multiply stage of the inversion chain.
// ----------------------------------------------------------------------------
module gfi_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [gfi_pkg::DataW-1:0] in_pow,
  input  wire logic [gfi_pkg::DataW-1:0] in_base,
  output logic                           out_valid,
  output logic [gfi_pkg::DataW-1:0]      out_pow,
  output logic [gfi_pkg::DataW-1:0]      out_base
);
  import gfi_pkg::*;
  logic             valid_r, valid_nxt;
  logic [DataW-1:0] pow_r, pow_nxt;
  logic [DataW-1:0] base_r, base_nxt;

  always_comb begin
    valid_nxt = in_valid;
    pow_nxt   = pow_r;
    base_nxt  = base_r;
    if (in_valid) begin
      pow_nxt  = gf_mul(gf_sq(in_pow), in_base);
      base_nxt = in_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r  <= pow_nxt;
    base_r <= base_nxt;
  end

  assign out_valid = valid_r;
  assign out_pow   = pow_r;
  assign out_base  = base_r;
endmodule
`default_nettype wire

@@ hw/rtl/gf256_inverse_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_inverse_top
// GF(2^8) multiplicative inverse modulo 0x11B as the power x^254.
// Each accepted byte passes through the six cell registers and then the output register to out_valid.
// A new byte is accepted only while busy is low; busy is high while a cell holds data.
// Six cells each turn p into p*p*x, reaching x^127, and the output stage squares it.
// Zero maps to zero by the same arithmetic.
// Reset clears the valid bits only; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module gf256_inverse_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [gfi_pkg::DataW-1:0] in_value,
  output logic                           out_valid,
  output logic [gfi_pkg::DataW-1:0]      out_inverse
);
  import gfi_pkg::*;

  logic [NumCells:0]            valid_vec;
  logic [NumCells:0][DataW-1:0] pow_vec;
  logic [NumCells:0][DataW-1:0] base_vec;
  logic                         accept;
  logic                         out_valid_r;
  logic [DataW-1:0]             out_inverse_r;

  assign busy         = |valid_vec[NumCells:1];
  assign accept       = start & ~busy;
  assign valid_vec[0] = accept;
  assign pow_vec[0]   = in_value;
  assign base_vec[0]  = in_value;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    gfi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_vec[i]),
      .in_pow   (pow_vec[i]),
      .in_base  (base_vec[i]),
      .out_valid(valid_vec[i+1]),
      .out_pow  (pow_vec[i+1]),
      .out_base (base_vec[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_vec[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (valid_vec[NumCells]) begin
      out_inverse_r <= gf_sq(pow_vec[NumCells]);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;

  logic unused_ok;
  assign unused_ok = ^base_vec[NumCells];

  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid longer than one cycle");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({valid_vec[NumCells:1], out_valid_r}))
    else $error("more than one transaction in flight");
endmodule
`default_nettype wire
